@@ src/fixed_point_alu_core_defines.svh @@
// ----------------------------------------------------------------------------
// fixed_point_alu_core_defines
// assertion macros used by the fixed-point alu core
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_CORE_DEFINES_SVH
`define FIXED_POINT_ALU_CORE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define FPA_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("fixed-point alu check failed");

// next-cycle implication, checked while out of reset
`define FPA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("fixed-point alu check failed");

`endif

@@ src/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg
// types and constants shared by the fixed-point alu files
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpa_pkg;

   localparam int DATA_W = 32;
   localparam int NUM_W  = 63;   // dividend magnitude after the fraction shift
   localparam int QUO_W  = 33;   // quotient bits resolved by the divider
   localparam int DIV_LAT = QUO_W + 2;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_MIN      = 4'd4,
      OP_MAX      = 4'd5,
      OP_INC      = 4'd6,
      OP_DEC      = 4'd7,
      OP_TO_INT   = 4'd8,
      OP_FROM_INT = 4'd9
   } op_type;

   typedef struct packed {
      logic                     valid;
      op_type                   op;
      logic                     gt;
      logic                     eq;
      logic                     lt;
      logic signed [DATA_W-1:0] res;
      logic                     ovf;
      logic                     dz;
      logic                     neg;
   } pipe_type;

endpackage

@@ src/fixed_point_alu_core.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu_core
// signed 32-bit fixed-point alu with saturation and compare flags
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output stalls, and returns one result per
// item, in order. An item passes 38 register stages before its result is
// presented. The depth is set by the divider, which resolves one
// quotient bit per pipeline stage (33 stages plus setup and rounding); all
// other operations travel alongside it so results never reorder. The whole
// pipeline advances together whenever the output register is empty or being
// taken, and it stalls with req_ready low while a result waits on rsp_ready.
// Multiply and divide round to nearest with ties away from zero, results that
// leave the 32-bit range saturate and raise the overflow flag, and divide by
// zero raises its own flag and saturates by the sign of the dividend.
`timescale 1ns / 1ps
`include "fixed_point_alu_core_defines.svh"

module fixed_point_alu_core #(
   parameter int FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [3:0]                        req_type,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DATA_W-1:0] req_operand_b,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [fpa_pkg::DATA_W-1:0] rsp_result_value,
   output logic                              rsp_a_greater,
   output logic                              rsp_a_equal,
   output logic                              rsp_a_less,
   output logic                              rsp_overflow_flag,
   output logic                              rsp_div_zero_flag
);
   import fpa_pkg::*;

   localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [63:0] MUL_HALF =
      (FRAC_BITS == 0) ? 64'd0 : (64'd1 << (FRAC_BITS - 1));

   // whole pipeline moves when the output slot is free or being drained
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // saturate a 33-bit sum to 32 bits
   function automatic logic [DATA_W:0] sat33(input logic signed [DATA_W:0] v);
      logic ovf;
      logic [DATA_W-1:0] r;
      ovf = (v[DATA_W] != v[DATA_W-1]);
      r   = ovf ? (v[DATA_W] ? S_MIN : S_MAX) : v[DATA_W-1:0];
      return {ovf, r};
   endfunction

   // ---------------- stage 1: input capture ----------------
   logic                     v1_ff;
   op_type                   op1_ff;
   logic signed [DATA_W-1:0] a1_ff, b1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
      if (en) begin
         op1_ff <= op_type'(req_type);
         a1_ff  <= req_operand_a;
         b1_ff  <= req_operand_b;
      end
   end

   // ---------------- stage 2: simple ops, multiply, divide setup ----------------
   pipe_type                 sp_in;
   logic signed [63:0]       prod_in;
   logic [NUM_W-1:0]         num_in;
   logic [DATA_W-1:0]        den_in;
   logic [DATA_W-1:0]        abs_a, abs_b;
   logic [DATA_W:0]          add_s, sub_s, inc_s, dec_s;
   logic signed [63:0]       fi_w;

   assign abs_a = a1_ff[DATA_W-1] ? DATA_W'(-a1_ff) : DATA_W'(a1_ff);
   assign abs_b = b1_ff[DATA_W-1] ? DATA_W'(-b1_ff) : DATA_W'(b1_ff);
   assign add_s = sat33({a1_ff[DATA_W-1], a1_ff} + {b1_ff[DATA_W-1], b1_ff});
   assign sub_s = sat33({a1_ff[DATA_W-1], a1_ff} - {b1_ff[DATA_W-1], b1_ff});
   assign inc_s = sat33({a1_ff[DATA_W-1], a1_ff} + (DATA_W+1)'(1));
   assign dec_s = sat33({a1_ff[DATA_W-1], a1_ff} - (DATA_W+1)'(1));
   assign fi_w  = 64'(a1_ff) <<< FRAC_BITS;
   assign prod_in = 64'(a1_ff) * 64'(b1_ff);
   assign num_in  = NUM_W'(abs_a) << FRAC_BITS;
   assign den_in  = abs_b;

   always_comb begin
      sp_in       = '0;
      sp_in.valid = v1_ff;
      sp_in.op    = op1_ff;
      sp_in.gt    = (a1_ff > b1_ff);
      sp_in.eq    = (a1_ff == b1_ff);
      sp_in.lt    = (a1_ff < b1_ff);
      sp_in.neg   = a1_ff[DATA_W-1] ^ b1_ff[DATA_W-1];
      case (op1_ff)
         OP_ADD: {sp_in.ovf, sp_in.res} = add_s;
         OP_SUB: {sp_in.ovf, sp_in.res} = sub_s;
         OP_INC: {sp_in.ovf, sp_in.res} = inc_s;
         OP_DEC: {sp_in.ovf, sp_in.res} = dec_s;
         OP_MIN: sp_in.res = (a1_ff < b1_ff) ? a1_ff : b1_ff;
         OP_MAX: sp_in.res = (a1_ff > b1_ff) ? a1_ff : b1_ff;
         OP_TO_INT: sp_in.res = a1_ff >>> FRAC_BITS;
         OP_FROM_INT: begin
            if (fi_w > 64'(S_MAX)) begin
               sp_in.ovf = 1'b1;
               sp_in.res = S_MAX;
            end else if (fi_w < 64'(S_MIN)) begin
               sp_in.ovf = 1'b1;
               sp_in.res = S_MIN;
            end else begin
               sp_in.res = fi_w[DATA_W-1:0];
            end
         end
         OP_DIV: begin
            // divide by zero: saturate by the dividend's sign
            if (b1_ff == '0) begin
               sp_in.dz  = 1'b1;
               sp_in.res = (a1_ff > 0) ? S_MAX : ((a1_ff < 0) ? S_MIN : '0);
            end
         end
         OP_MUL: sp_in.res = '0;
         default: sp_in.res = '0;
      endcase
   end

   // side pipe, aligned with the divider stages
   pipe_type           sp_ff [0:DIV_LAT];
   logic signed [63:0] prod_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DATA_W-1:0]  den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff[0].valid <= 1'b0;
      end else if (en) begin
         sp_ff[0].valid <= sp_in.valid;
      end
      if (en) begin
         sp_ff[0].op  <= sp_in.op;
         sp_ff[0].gt  <= sp_in.gt;
         sp_ff[0].eq  <= sp_in.eq;
         sp_ff[0].lt  <= sp_in.lt;
         sp_ff[0].res <= sp_in.res;
         sp_ff[0].ovf <= sp_in.ovf;
         sp_ff[0].dz  <= sp_in.dz;
         sp_ff[0].neg <= sp_in.neg;
         prod_ff      <= prod_in;
         num_ff       <= num_in;
         den_ff       <= den_in;
      end
   end

   // ---------------- multiply: magnitude, then round and saturate ----------------
   logic [63:0] mul_mag_ff;
   logic [63:0] mul_rnd;
   logic        mul_sat;
   logic signed [DATA_W-1:0] mul_res;

   always_ff @(posedge clock) begin
      if (en) begin
         mul_mag_ff <= prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
      end
   end

   assign mul_rnd = (mul_mag_ff + MUL_HALF) >> FRAC_BITS;
   // negative side may reach 2^31, positive side stops one short
   assign mul_sat = sp_ff[1].neg ? (mul_rnd > (64'd1 << (DATA_W-1)))
                                 : (mul_rnd > ((64'd1 << (DATA_W-1)) - 64'd1));
   assign mul_res = mul_sat ? (sp_ff[1].neg ? S_MIN : S_MAX)
                            : (sp_ff[1].neg ? -mul_rnd[DATA_W-1:0] : mul_rnd[DATA_W-1:0]);

   for (genvar k = 1; k <= DIV_LAT; k++) begin : g_side
      pipe_type nxt;
      always_comb begin
         nxt = sp_ff[k-1];
         if (k == 2 && sp_ff[k-1].op == OP_MUL) begin
            nxt.res = mul_res;
            nxt.ovf = mul_sat;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sp_ff[k].valid <= 1'b0;
         end else if (en) begin
            sp_ff[k].valid <= nxt.valid;
         end
         if (en) begin
            sp_ff[k].op  <= nxt.op;
            sp_ff[k].gt  <= nxt.gt;
            sp_ff[k].eq  <= nxt.eq;
            sp_ff[k].lt  <= nxt.lt;
            sp_ff[k].res <= nxt.res;
            sp_ff[k].ovf <= nxt.ovf;
            sp_ff[k].dz  <= nxt.dz;
            sp_ff[k].neg <= nxt.neg;
         end
      end
   end

   // ---------------- divider ----------------
   logic [QUO_W:0] div_mag;
   logic           div_big;

   fpa_divider u_div (
      .clock   (clock),
      .en      (en),
      .num_in  (num_ff),
      .den_in  (den_ff),
      .mag_out (div_mag),
      .big_out (div_big)
   );

   // ---------------- output stage: divide sign and saturation ----------------
   pipe_type                 last;
   logic [QUO_W:0]           div_lim;
   logic                     div_sat;
   logic signed [DATA_W-1:0] out_res;
   logic                     out_ovf;

   assign last    = sp_ff[DIV_LAT];
   assign div_lim = last.neg ? (QUO_W+1)'(unsigned'(S_MIN)) : (QUO_W+1)'(unsigned'(S_MAX));
   assign div_sat = div_big || (div_mag > div_lim);

   always_comb begin
      out_res = last.res;
      out_ovf = last.ovf;
      if (last.op == OP_DIV && !last.dz) begin
         out_ovf = div_sat;
         if (div_sat) begin
            out_res = last.neg ? S_MIN : S_MAX;
         end else begin
            out_res = last.neg ? -div_mag[DATA_W-1:0] : div_mag[DATA_W-1:0];
         end
      end
   end

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_res_ff;
   logic                     rsp_gt_ff, rsp_eq_ff, rsp_lt_ff, rsp_ovf_ff, rsp_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= last.valid;
      end
      if (en) begin
         rsp_res_ff <= out_res;
         rsp_gt_ff  <= last.gt;
         rsp_eq_ff  <= last.eq;
         rsp_lt_ff  <= last.lt;
         rsp_ovf_ff <= out_ovf;
         rsp_dz_ff  <= last.dz;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_value  = rsp_res_ff;
   assign rsp_a_greater     = rsp_gt_ff;
   assign rsp_a_equal       = rsp_eq_ff;
   assign rsp_a_less        = rsp_lt_ff;
   assign rsp_overflow_flag = rsp_ovf_ff;
   assign rsp_div_zero_flag = rsp_dz_ff;

   // ---------------- checks ----------------
   // exactly one compare outcome per result
   `FPA_ASSERT_NOW(a_cmp_onehot, clock, reset, rsp_valid,
      $onehot({rsp_a_greater, rsp_a_equal, rsp_a_less}))
   // divide by zero never also reports overflow
   `FPA_ASSERT_NOW(a_dz_no_ovf, clock, reset, rsp_valid && rsp_div_zero_flag,
      !rsp_overflow_flag)
   // a saturated result sits at one of the range limits
   `FPA_ASSERT_NOW(a_ovf_limit, clock, reset, rsp_valid && rsp_overflow_flag,
      (rsp_result_value == S_MAX) || (rsp_result_value == S_MIN))

endmodule

@@ src/fpa_divider.sv @@
// ----------------------------------------------------------------------------
// fpa_divider
// pipelined restoring divider, one quotient bit per stage, rounds half up
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_divider (
   input  logic                       clock,
   input  logic                       en,
   input  logic [fpa_pkg::NUM_W-1:0]  num_in,
   input  logic [fpa_pkg::DATA_W-1:0] den_in,
   output logic [fpa_pkg::QUO_W:0]    mag_out,
   output logic                       big_out
);
   import fpa_pkg::*;

   logic [DATA_W-1:0] rem_ff  [0:QUO_W];
   logic [QUO_W-1:0]  bits_ff [0:QUO_W];
   logic [DATA_W-1:0] den_ff  [0:QUO_W];
   logic              big_ff  [0:QUO_W];
   logic [QUO_W:0]    mag_ff;
   logic              big_out_ff;

   logic [DATA_W-1:0] hi_in;
   assign hi_in = DATA_W'(num_in[NUM_W-1:QUO_W]);

   // quotient at or above 2^33 is flagged up front
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= hi_in;
         bits_ff[0] <= num_in[QUO_W-1:0];
         den_ff[0]  <= den_in;
         big_ff[0]  <= (hi_in >= den_in);
      end
   end

   // bits_ff shifts dividend bits out the top and quotient bits in the bottom
   for (genvar i = 1; i <= QUO_W; i++) begin : g_step
      logic [DATA_W:0] trial;
      logic [DATA_W:0] diff;
      logic            ge;
      assign trial = {rem_ff[i-1], bits_ff[i-1][QUO_W-1]};
      assign ge    = (trial >= {1'b0, den_ff[i-1]});
      assign diff  = trial - {1'b0, den_ff[i-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            bits_ff[i] <= {bits_ff[i-1][QUO_W-2:0], ge};
            den_ff[i]  <= den_ff[i-1];
            big_ff[i]  <= big_ff[i-1];
         end
      end
   end

   logic round_up;
   assign round_up = ({rem_ff[QUO_W], 1'b0} >= {1'b0, den_ff[QUO_W]});

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff     <= {1'b0, bits_ff[QUO_W]} + (QUO_W+1)'(round_up);
         big_out_ff <= big_ff[QUO_W];
      end
   end

   assign mag_out = mag_ff;
   assign big_out = big_out_ff;

endmodule
